// ===== hdl/rris_pkg.sv =====
// Shared types and constants of the round-robin interval scheduler.
package rris_pkg;

  localparam int ENTRIES       = 3;
  localparam int NUM_INTERVALS = 3;
  localparam int TICK_W        = 32;
  localparam int INTERVAL_W    = 24;
  localparam int PERIOD_W      = 10;
  localparam int ENTRY_W       = 2;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 24;

  typedef logic [TICK_W-1:0]     tick_t;
  typedef logic [INTERVAL_W-1:0] interval_t;
  typedef logic [PERIOD_W-1:0]   period_t;
  typedef logic [ENTRY_W-1:0]    entry_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

  // Register indexes on the configuration port
  localparam cfg_idx_t REG_INTERVAL_A  = 2'd0;
  localparam cfg_idx_t REG_INTERVAL_B  = 2'd1;
  localparam cfg_idx_t REG_INTERVAL_C  = 2'd2;
  localparam cfg_idx_t REG_TICK_PERIOD = 2'd3;

  localparam interval_t INTERVAL_A_RST  = 24'd1000;
  localparam interval_t INTERVAL_B_RST  = 24'd1000;
  localparam interval_t INTERVAL_C_RST  = 24'd2000;
  localparam period_t   TICK_PERIOD_RST = 10'd1;

  typedef struct packed {
    logic [NUM_INTERVALS-1:0][INTERVAL_W-1:0] interval;
    period_t                                  period;
  } rris_cfg_t;

endpackage

// ===== hdl/rris_if.sv =====
// Valid/ready channel interfaces for scheduling passes and their results.
interface rris_in_if;
  import rris_pkg::*;
  logic  valid;
  logic  ready;
  tick_t now_tick;
  logic  send_ok;
  modport source (output valid, output now_tick, output send_ok, input ready);
  modport sink (input valid, input now_tick, input send_ok, output ready);
endinterface

interface rris_out_if;
  import rris_pkg::*;
  logic   valid;
  logic   ready;
  logic   fired;
  entry_t chosen_entry;
  logic   sent;
  modport source (output valid, output fired, output chosen_entry, output sent, input ready);
  modport sink (input valid, input fired, input chosen_entry, input sent, output ready);
endinterface

// ===== hdl/rris_cfg_regs.sv =====
// Configuration register bank: entry intervals and tick period.
module rris_cfg_regs
  import rris_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  cfg_idx_t              cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output rris_cfg_t             cfg_o
);

  rris_cfg_t cfg_r;
  rris_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        REG_INTERVAL_A:  cfg_nxt.interval[0] = cfg_wdata[INTERVAL_W-1:0];
        REG_INTERVAL_B:  cfg_nxt.interval[1] = cfg_wdata[INTERVAL_W-1:0];
        REG_INTERVAL_C:  cfg_nxt.interval[2] = cfg_wdata[INTERVAL_W-1:0];
        REG_TICK_PERIOD: cfg_nxt.period      = cfg_wdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.interval[0] <= INTERVAL_A_RST;
      cfg_r.interval[1] <= INTERVAL_B_RST;
      cfg_r.interval[2] <= INTERVAL_C_RST;
      cfg_r.period      <= TICK_PERIOD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

// ===== hdl/rris_elapsed_unit.sv =====
// Shared elapsed-time unit: tick difference times period, then compare to interval.
module rris_elapsed_unit
  import rris_pkg::*;
(
  input  logic      clk,
  input  logic      load,
  input  tick_t     now_tick,
  input  tick_t     last_tick,
  input  period_t   period,
  input  interval_t interval,
  output logic      due
);

  tick_t              diff;
  tick_t              prod;
  tick_t              elapsed_r;
  interval_t          interval_r;

  // wraps modulo 2^32, as the tick counter does
  assign diff = now_tick - last_tick;
  assign prod = diff * TICK_W'(period);

  always_ff @(posedge clk) begin
    if (load) begin
      elapsed_r  <= prod;
      interval_r <= interval;
    end
  end

  assign due = (elapsed_r >= TICK_W'(interval_r));

endmodule

// ===== hdl/round_robin_interval_scheduler_core.sv =====
// Round-robin interval scheduler: one pass per input word, one result word per pass.
// Each input word is a scheduling pass. Entries are checked one at a time starting at
// the round-robin cursor; each check runs on the single shared subtract-multiply-compare
// unit (product registered in S_MUL, then compared in S_CMP). A pass examines one to
// three entries and then waits in S_FIN to hand its word over to the output register,
// and stays there while that register still holds a word the receiver has not taken.
// in_ready is high only between passes, so a new pass is accepted only once the last
// has left S_FIN; a finished result may wait in the output register while the next
// pass is accepted. No clearing pass after reset is needed.
module round_robin_interval_scheduler_core
  import rris_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  rris_in_if.sink               in_ch,
  rris_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  cfg_idx_t              cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  localparam entry_t LAST_ENTRY = entry_t'(ENTRIES - 1);

  rris_cfg_t  cfg;
  logic       due;
  logic       in_fire;
  logic       slot_free;
  entry_t     idx_next;

  logic [1:0] state_r, state_nxt;
  tick_t      now_r, now_nxt;
  logic       send_ok_r, send_ok_nxt;
  entry_t     idx_r, idx_nxt;
  entry_t     cnt_r, cnt_nxt;
  entry_t     cursor_r, cursor_nxt;
  logic       res_fired_r, res_fired_nxt;
  entry_t     res_entry_r, res_entry_nxt;
  logic       res_sent_r, res_sent_nxt;
  tick_t      last_r [ENTRIES];
  logic       out_valid_r;
  logic       out_fired_r;
  entry_t     out_entry_r;
  logic       out_sent_r;

  rris_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  rris_elapsed_unit u_unit (
    .clk       (clk),
    .load      (state_r == S_MUL),
    .now_tick  (now_r),
    .last_tick (last_r[idx_r]),
    .period    (cfg.period),
    .interval  (cfg.interval[idx_r]),
    .due       (due)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid_r || out_ch.ready;
  assign idx_next    = (idx_r == LAST_ENTRY) ? '0 : idx_r + entry_t'(1);

  always_comb begin
    state_nxt     = state_r;
    now_nxt       = now_r;
    send_ok_nxt   = send_ok_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    cursor_nxt    = cursor_r;
    res_fired_nxt = res_fired_r;
    res_entry_nxt = res_entry_r;
    res_sent_nxt  = res_sent_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          now_nxt     = in_ch.now_tick;
          send_ok_nxt = in_ch.send_ok;
          idx_nxt     = cursor_r;
          cnt_nxt     = '0;
          state_nxt   = S_MUL;
        end
      end
      S_MUL: state_nxt = S_CMP;
      S_CMP: begin
        if (due) begin
          res_fired_nxt = 1'b1;
          res_entry_nxt = idx_r;
          res_sent_nxt  = send_ok_r;
          cursor_nxt    = idx_next;
          state_nxt     = S_FIN;
        end else if (cnt_r == LAST_ENTRY) begin
          // nothing due: report an empty pass, state untouched
          res_fired_nxt = 1'b0;
          res_entry_nxt = '0;
          res_sent_nxt  = 1'b0;
          state_nxt     = S_FIN;
        end else begin
          idx_nxt   = idx_next;
          cnt_nxt   = cnt_r + entry_t'(1);
          state_nxt = S_MUL;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cursor_r <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        last_r[i] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      cursor_r <= cursor_nxt;
      if (state_r == S_CMP && due && send_ok_r) begin
        last_r[idx_r] <= now_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    now_r       <= now_nxt;
    send_ok_r   <= send_ok_nxt;
    idx_r       <= idx_nxt;
    cnt_r       <= cnt_nxt;
    res_fired_r <= res_fired_nxt;
    res_entry_r <= res_entry_nxt;
    res_sent_r  <= res_sent_nxt;
  end

  // Output register: load the finished word once the slot is free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_FIN && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FIN && slot_free) begin
      out_fired_r <= res_fired_r;
      out_entry_r <= res_entry_r;
      out_sent_r  <= res_sent_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.fired        = out_fired_r;
  assign out_ch.chosen_entry = out_entry_r;
  assign out_ch.sent         = out_sent_r;

`ifndef SYNTHESIS
  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_MUL && cnt_r == '0)
    else $error("accepted pass did not start a scan");

  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= LAST_ENTRY)
    else $error("round-robin cursor out of range");

  a_cursor_moves_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(cursor_r) |-> $past(state_r) == S_CMP && $past(due))
    else $error("cursor moved without a due entry");

  a_sent_needs_fire: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_fired_r |-> !out_sent_r && out_entry_r == '0)
    else $error("empty pass reported a send or an entry");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(out_entry_r))
    else $error("pending result word overwritten");
`endif

endmodule

// ===== test/rris_sched_checker.sv =====
// Checker for the round-robin interval scheduler: predicts each pass and compares result words.
module rris_sched_checker
  import rris_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  rris_in_if                    in_mon,
  rris_out_if                   out_mon,
  input  logic                  cfg_we,
  input  cfg_idx_t              cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    awaited
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic   fired;
    entry_t chosen_entry;
    logic   sent;
  } pass_result_t;

  interval_t    interval_ms [ENTRIES];
  period_t      tick_period;
  tick_t        last_sent [ENTRIES];
  entry_t       rr_next;
  pass_result_t expected_results [$];
  pass_result_t want;

  // Scan from the cursor, pick the first due entry, update the timestamp if it went out
  function automatic pass_result_t schedule_pass(tick_t now, logic send_ok);
    pass_result_t res;
    tick_t        elapsed;
    int           start;
    int           e;
    bit           found;
    res   = '0;
    found = 1'b0;
    start = rr_next % ENTRIES;
    for (int i = 0; i < ENTRIES; i++) begin
      e       = (start + i) % ENTRIES;
      elapsed = (now - last_sent[e]) * tick_period;
      if (!found && elapsed >= tick_t'(interval_ms[e])) begin
        found            = 1'b1;
        res.fired        = 1'b1;
        res.chosen_entry = entry_t'(e);
        if (send_ok) begin
          last_sent[e] = now;
          res.sent     = 1'b1;
        end
        rr_next = entry_t'((e + 1) % ENTRIES);
      end
    end
    return res;
  endfunction

  initial begin
    fail_count = 0;
    awaited    = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      interval_ms[0] = INTERVAL_A_RST;
      interval_ms[1] = INTERVAL_B_RST;
      interval_ms[2] = INTERVAL_C_RST;
      tick_period    = TICK_PERIOD_RST;
      for (int i = 0; i < ENTRIES; i++) last_sent[i] = '0;
      rr_next = '0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_INTERVAL_A:  interval_ms[0] = cfg_wdata[INTERVAL_W-1:0];
          REG_INTERVAL_B:  interval_ms[1] = cfg_wdata[INTERVAL_W-1:0];
          REG_INTERVAL_C:  interval_ms[2] = cfg_wdata[INTERVAL_W-1:0];
          REG_TICK_PERIOD: tick_period    = cfg_wdata[PERIOD_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        expected_results.push_back(schedule_pass(in_mon.now_tick, in_mon.send_ok));
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          $display("%0t ERROR result word with none expected: fired %0d entry %0d sent %0d",
                   $time, out_mon.fired, out_mon.chosen_entry, out_mon.sent);
        end else begin
          want = expected_results.pop_front();
          if (out_mon.fired !== want.fired) begin
            fail_count++;
            $display("%0t ERROR fired: expected %0d actual %0d",
                     $time, want.fired, out_mon.fired);
          end
          if (out_mon.chosen_entry !== want.chosen_entry) begin
            fail_count++;
            $display("%0t ERROR chosen_entry: expected %0d actual %0d",
                     $time, want.chosen_entry, out_mon.chosen_entry);
          end
          if (out_mon.sent !== want.sent) begin
            fail_count++;
            $display("%0t ERROR sent: expected %0d actual %0d",
                     $time, want.sent, out_mon.sent);
          end
        end
      end
    end
    awaited = expected_results.size();
  end

endmodule

// ===== test/tb_round_robin_interval_scheduler_core.sv =====
// Testbench top for the round-robin interval scheduler: stimulus, idling phases and verdict.
module tb_round_robin_interval_scheduler_core;
  timeunit 1ns;
  timeprecision 1ps;
  import rris_pkg::*;

  localparam int CYCLE_LIMIT      = 400000;
  localparam int HOLD_CYCLES      = 300;
  localparam int DRAIN_CYCLES     = 8;
  localparam int RANDOM_PER_PHASE = 175;
  localparam int NUM_PHASES       = 7;

  // Directed passes under reset settings: {send_ok, now_tick}
  localparam logic [0:19][32:0] DIRECTED_PASSES = {
    {1'b1, 32'h0000_0000}, {1'b1, 32'd999},       {1'b0, 32'd1000},      {1'b1, 32'd1000},
    {1'b1, 32'd1500},      {1'b1, 32'd2000},      {1'b1, 32'd2000},      {1'b1, 32'd2000},
    {1'b0, 32'hFFFF_FFFF}, {1'b1, 32'hFFFF_FFFF}, {1'b1, 32'h0000_0100}, {1'b1, 32'h8000_0000},
    {1'b1, 32'h7FFF_FFFF}, {1'b0, 32'hAAAA_AAAA}, {1'b1, 32'h5555_5555}, {1'b1, 32'h5555_5555},
    {1'b1, 32'h0000_0000}, {1'b0, 32'h0000_0000}, {1'b1, 32'hFFFF_FFFF}, {1'b1, 32'h0000_0001}
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_idx_t              cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    awaited;
  int                    send_idle_pct;
  int                    recv_stall_pct;
  int                    hold_serial;
  int                    cycle_count;

  rris_in_if  in_ch ();
  rris_out_if out_ch ();

  round_robin_interval_scheduler_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  rris_sched_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .awaited    (awaited)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Offer one pass word, idling beforehand at the current rate, and hold it until taken
  task automatic offer_pass(input tick_t now, input logic ok);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_ch.valid    = 1'b0;
      in_ch.now_tick = $urandom;
      in_ch.send_ok  = $urandom_range(1) == 1;
    end
    @(negedge clk);
    in_ch.valid    = 1'b1;
    in_ch.now_tick = now;
    in_ch.send_ok  = ok;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Result side: random stalls, plus a long hold-off whenever hold_serial moves
  initial begin
    int hold_left;
    int hold_seen;
    hold_left    = 0;
    hold_seen    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_serial != hold_seen) begin
        hold_seen = hold_serial;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = $urandom_range(99) >= recv_stall_pct;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("round_robin_interval_scheduler_core: mismatch");
    $finish;
  end

  initial begin
    tick_t                 tick_now;
    int                    step_max;
    logic [CFG_DATA_W-1:0] ival_a;
    logic [CFG_DATA_W-1:0] ival_b;
    logic [CFG_DATA_W-1:0] ival_c;
    logic [CFG_DATA_W-1:0] period_word;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = REG_INTERVAL_A;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.now_tick = '0;
    in_ch.send_ok  = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_serial    = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    for (int k = 0; k < 20; k++)
      offer_pass(DIRECTED_PASSES[k][31:0], DIRECTED_PASSES[k][32]);

    tick_now = '0;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      // Drain before touching the registers
      @(negedge clk);
      in_ch.valid = 1'b0;
      wait (awaited == 0);
      repeat (DRAIN_CYCLES) @(negedge clk);

      ival_a      = 24'd1000;
      ival_b      = 24'd1000;
      ival_c      = 24'd2000;
      period_word = 24'd1;
      step_max    = 1500;
      case (phase)
        1: begin
          // zero intervals: always due; upper period bits must be dropped
          ival_a      = 24'd0;
          ival_b      = 24'd0;
          ival_c      = 24'd0;
          period_word = 24'hFFFBE8;
          step_max    = 100;
        end
        2: begin
          ival_a      = 24'hFFFFFF;
          ival_b      = 24'hFFFFFF;
          ival_c      = 24'hFFFFFF;
          period_word = 24'd1000;
          step_max    = 0;
        end
        3: begin
          ival_a      = 24'd5;
          ival_b      = 24'd17;
          ival_c      = 24'd40;
          period_word = 24'd1;
          step_max    = 30;
        end
        4: begin
          // period of zero: only the zero interval can be due
          ival_a      = 24'd0;
          ival_b      = 24'd3;
          ival_c      = 24'hFFFFFF;
          period_word = 24'hFFFC00;
          step_max    = 50;
        end
        5: begin
          ival_a      = CFG_DATA_W'($urandom_range(3000));
          ival_b      = CFG_DATA_W'($urandom_range(3000));
          ival_c      = CFG_DATA_W'($urandom_range(3000));
          period_word = CFG_DATA_W'(($urandom_range(16383) << PERIOD_W) |
                                    $urandom_range(20, 1));
          step_max    = 200;
        end
        6: begin
          ival_a      = 24'd1;
          ival_b      = 24'd1;
          ival_c      = 24'd1;
          period_word = 24'd1023;
          step_max    = 4;
        end
        default: ;
      endcase
      if (phase != 0) begin
        write_reg(REG_INTERVAL_A, ival_a);
        write_reg(REG_INTERVAL_B, ival_b);
        write_reg(REG_INTERVAL_C, ival_c);
        write_reg(REG_TICK_PERIOD, period_word);
      end

      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      // Long hold-off on the result side while passes keep coming
      if (phase == 4) hold_serial++;

      repeat (RANDOM_PER_PHASE) begin
        if ($urandom_range(9) == 0) begin
          offer_pass($urandom, $urandom_range(1) == 1);
        end else begin
          if (step_max == 0) tick_now += $urandom;
          else tick_now += $urandom_range(step_max);
          offer_pass(tick_now, $urandom_range(3) != 0);
        end
      end
    end

    @(negedge clk);
    in_ch.valid = 1'b0;
    wait (awaited == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("round_robin_interval_scheduler_core: match");
    end else begin
      $display("round_robin_interval_scheduler_core: mismatch");
    end
    $finish;
  end

endmodule
